>>> design/lnlw_pkg.sv
// ---------------------------------------------------------------------------
// lnlw_pkg
// Shared types, character codes and the byte sequence lookup for the
// 4-bit LCD line writer.
// ---------------------------------------------------------------------------
package lnlw_pkg;

    // Request kinds
    localparam logic [1:0] KIND_INIT = 2'd0;
    localparam logic [1:0] KIND_FREQ = 2'd1;
    localparam logic [1:0] KIND_RES  = 2'd2;

    // ADC scaling
    localparam int unsigned ADC_MAX    = 4095;
    localparam int unsigned FULL_SCALE = 5000;
    localparam int unsigned CODE_W     = 12;
    localparam int unsigned PROD_W     = 25;
    localparam int unsigned QUO_W      = 13;

    // Power-up wake nibbles
    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;

    // Commands
    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_LINE1    = 8'h80;
    localparam logic [7:0] CMD_LINE2    = 8'hC0;

    // Characters
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_OHM   = 8'hF4;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    // Last strobe index of each sequence
    localparam logic [4:0] LAST_INIT = 5'd11;
    localparam logic [4:0] LAST_FREQ = 5'd17;
    localparam logic [4:0] LAST_RES  = 5'd15;

    // One queued job: kind plus four BCD digits, thousands first
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] digits;
    } job_t;

    // One nibble strobe of a sequence
    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } strobe_t;

    // Look up strobe idx of the sequence for a job
    function automatic strobe_t strobe_info(input logic [1:0] kind,
                                            input logic [4:0] idx,
                                            input logic [15:0] digits);
        strobe_t    r;
        logic [7:0] b;
        logic [7:0] dch;
        logic [3:0] bidx;
        logic       rs;
        bidx = idx[4:1];
        // digit character for byte slots 3..6
        case (bidx)
            4'd3:    dch = {CH_DIGIT_HI, digits[15:12]};
            4'd4:    dch = {CH_DIGIT_HI, digits[11:8]};
            4'd5:    dch = {CH_DIGIT_HI, digits[7:4]};
            default: dch = {CH_DIGIT_HI, digits[3:0]};
        endcase
        b      = 8'h00;
        rs     = 1'b1;
        r.last = 1'b1;
        case (kind)
            KIND_INIT:
            begin
                rs     = 1'b0;
                r.last = (idx == LAST_INIT);
                case (bidx)
                    4'd0:    b = {NIB_WAKE, NIB_WAKE};
                    4'd1:    b = {NIB_WAKE, idx[0] ? NIB_4BIT : NIB_WAKE};
                    4'd2:    b = CMD_FUNC_SET;
                    4'd3:    b = CMD_DISP_ON;
                    4'd4:    b = CMD_ENTRY;
                    default: b = CMD_CLEAR;
                endcase
            end
            KIND_FREQ:
            begin
                r.last = (idx == LAST_FREQ);
                case (bidx)
                    4'd0:
                    begin
                        b  = CMD_LINE1;
                        rs = 1'b0;
                    end
                    4'd1:    b = CH_F;
                    4'd2:    b = CH_COLON;
                    4'd7:    b = CH_H;
                    4'd8:    b = CH_Z;
                    default: b = dch;
                endcase
            end
            KIND_RES:
            begin
                r.last = (idx == LAST_RES);
                case (bidx)
                    4'd0:
                    begin
                        b  = CMD_LINE2;
                        rs = 1'b0;
                    end
                    4'd1:    b = CH_R;
                    4'd2:    b = CH_COLON;
                    4'd7:    b = CH_OHM;
                    default: b = dch;
                endcase
            end
            default:
            begin
                b = 8'h00;
            end
        endcase
        // wake strobes in the init sequence are single nibbles (low half)
        if (kind == KIND_INIT && bidx < 4'd2)
            r.nib = b[3:0];
        else
            r.nib = idx[0] ? b[3:0] : b[7:4];
        r.rs = rs;
        return r;
    endfunction

endpackage

>>> design/lnlw_front.sv
// ---------------------------------------------------------------------------
// lnlw_front
// Takes requests, scales the ADC code of a resistance request (multiply,
// then a fold that divides by the full-scale code 2^12 - 1) and converts
// the value to four BCD digits with a 16-step shift-add-3 loop before
// pushing the job into the queue; an init request is queued directly.
// ---------------------------------------------------------------------------
module lnlw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  logic [15:0]       value,
    output logic              busy,
    input  logic              full,
    output logic              push,
    output lnlw_pkg::job_t    job
);
    import lnlw_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_BCD  = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    localparam int unsigned       SUM_W    = QUO_W + 1;
    localparam logic [PROD_W-1:0] SCALE_K  = PROD_W'(FULL_SCALE);
    localparam logic [15:0]       CODE_SAT = 16'(ADC_MAX);
    localparam logic [SUM_W-1:0]  FOLD_ONE = SUM_W'(ADC_MAX);
    localparam logic [SUM_W-1:0]  FOLD_TWO = SUM_W'(2 * ADC_MAX);

    logic [2:0]        state_reg, state_next;
    logic [1:0]        kind_reg, kind_next;
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [15:0]       bin_reg, bin_next;
    logic [15:0]       bcd_reg, bcd_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [QUO_W-1:0]  fold_hi;
    logic [SUM_W-1:0]  fold_sum;
    logic [1:0]        fold_corr;
    logic [QUO_W-1:0]  quo;
    logic [15:0]       bcd_adj;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        rem_reg  <= rem_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
    end

    // Divide by 4095 = 2^12 - 1: x = hi*4096 + lo = hi*4095 + (hi + lo),
    // so x / 4095 = hi + (hi + lo) / 4095, and hi + lo stays below 3*4095
    assign fold_hi  = rem_reg[PROD_W-1:CODE_W];
    assign fold_sum = {1'b0, fold_hi} + {{(SUM_W-CODE_W){1'b0}}, rem_reg[CODE_W-1:0]};

    always_comb
    begin
        if (fold_sum >= FOLD_TWO)
            fold_corr = 2'd2;
        else if (fold_sum >= FOLD_ONE)
            fold_corr = 2'd1;
        else
            fold_corr = 2'd0;
    end

    assign quo = fold_hi + {{(QUO_W-2){1'b0}}, fold_corr};

    // Add 3 to every digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        rem_next   = rem_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind;
                    bcd_next  = 16'd0;
                    cnt_next  = 4'd15;
                    case (kind)
                        KIND_INIT:
                        begin
                            state_next = S_PUSH;
                        end
                        KIND_FREQ:
                        begin
                            bin_next   = value;
                            state_next = S_BCD;
                        end
                        KIND_RES:
                        begin
                            bin_next   = (value > CODE_SAT) ? CODE_SAT : value;
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                rem_next   = {{(PROD_W-CODE_W){1'b0}}, bin_reg[CODE_W-1:0]} * SCALE_K;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                bin_next   = {{(16-QUO_W){1'b0}}, quo};
                cnt_next   = 4'd15;
                state_next = S_BCD;
            end
            S_BCD:
            begin
                bcd_next = {bcd_adj[14:0], bin_reg[15]};
                bin_next = {bin_reg[14:0], 1'b0};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!full)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign push       = (state_reg == S_PUSH) && !full;
    assign job.kind   = kind_reg;
    assign job.digits = bcd_reg;

endmodule

>>> design/lnlw_queue.sv
// ---------------------------------------------------------------------------
// lnlw_queue
// Small show-ahead job queue between the converter and the byte sequencer.
// ---------------------------------------------------------------------------
module lnlw_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lnlw_pkg::job_t    wr_job,
    output logic              full,
    input  logic              pop,
    output lnlw_pkg::job_t    rd_job,
    output logic              empty
);
    import lnlw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    assign rd_job = slot_reg[rd_ptr_reg];
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

endmodule

>>> design/lnlw_back.sv
// ---------------------------------------------------------------------------
// lnlw_back
// Walks the strobe sequence of one job, three bytes per nibble, and drives
// the registered byte outputs. The next job is taken on the final byte.
// ---------------------------------------------------------------------------
module lnlw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  lnlw_pkg::job_t    rd_job,
    output logic              pop,
    output logic              strobe,
    output logic [7:0]        spi_byte,
    output logic              last
);
    import lnlw_pkg::*;

    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic       active_reg, active_next;
    job_t       job_reg, job_next;
    logic [4:0] idx_reg, idx_next;
    logic [1:0] phase_reg, phase_next;
    logic       strobe_reg;
    logic [7:0] spi_byte_reg, spi_byte_next;
    logic       last_reg, last_next;
    strobe_t    info;
    logic       job_end;

    assign info    = strobe_info(job_reg.kind, idx_reg, job_reg.digits);
    assign job_end = active_reg && info.last && (phase_reg == PH_DONE);
    assign pop     = !empty && (!active_reg || job_end);

    // Sequence walk
    always_comb
    begin
        active_next = active_reg;
        job_next    = job_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        if (pop)
        begin
            active_next = 1'b1;
            job_next    = rd_job;
            idx_next    = 5'd0;
            phase_next  = PH_LOW;
        end
        else if (active_reg)
        begin
            if (phase_reg == PH_DONE)
            begin
                phase_next = PH_LOW;
                idx_next   = idx_reg + 5'd1;
                if (info.last)
                    active_next = 1'b0;
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    // Byte: enable, register select, nibble
    assign spi_byte_next = {phase_reg == PH_HIGH, info.rs, 2'b00, info.nib};
    assign last_next     = job_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            idx_reg    <= 5'd0;
            phase_reg  <= PH_LOW;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= active_reg;
            last_reg   <= last_next;
            idx_reg    <= idx_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        spi_byte_reg <= spi_byte_next;
    end

    assign strobe   = strobe_reg;
    assign spi_byte = spi_byte_reg;
    assign last     = last_reg;

endmodule

>>> design/lcd_nibble_line_writer.sv
// Init requests go straight to the queue; a frequency line first runs the
// BCD loop, and a resistance line is scaled and folded before it.
// Throughput: one byte per cycle while a sequence runs, and across items
// while the queue holds the next job. busy is high while converting and
// stays high while the queue is full; an unused kind leaves busy low.
// Reset: asynchronous, active low; clears the queue and both sequencers.
// ---------------------------------------------------------------------------
// lcd_nibble_line_writer
// Request to byte stream converter for a 4-bit character LCD behind a
// shift register: converter front end, job queue, byte sequencer.
// ---------------------------------------------------------------------------
module lcd_nibble_line_writer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  kind,
    input  logic [15:0] value,
    output logic        busy,
    output logic        strobe,
    output logic [7:0]  spi_byte,
    output logic        last
);
    import lnlw_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    job_t wr_job;
    job_t rd_job;

    lnlw_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .value (value),
        .busy  (busy),
        .full  (full),
        .push  (push),
        .job   (wr_job)
    );

    lnlw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (full),
        .pop    (pop),
        .rd_job (rd_job),
        .empty  (empty)
    );

    lnlw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .rd_job   (rd_job),
        .pop      (pop),
        .strobe   (strobe),
        .spi_byte (spi_byte),
        .last     (last)
    );

`ifndef SYNTHESIS
    // last only marks a real byte
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    // bytes of one sequence are contiguous
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside a byte sequence");

    // an enable-high byte follows an enable-low byte
    a_en_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && spi_byte[7] |-> $past(strobe) && !$past(spi_byte[7]))
        else $error("enable pulse not preceded by setup byte");

    // the queue never takes a job while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
`endif

endmodule

>>> tb/tb_lcd_nibble_line_writer.sv
// ---------------------------------------------------------------------------
// tb_lcd_nibble_line_writer
// Self-checking bench for the 4-bit LCD line writer. Requests of every kind
// are driven through the start/busy handshake with random gaps. A built-in
// predictor expands each accepted item into the nibble strobe bytes that the
// panel should see. A scoreboard compares every strobed byte and last flag
// against the oldest expected entry.
// ---------------------------------------------------------------------------
module tb_lcd_nibble_line_writer;

    timeunit 1ns;
    timeprecision 1ps;

    // Request kinds; the fourth code is unused and must produce nothing
    localparam logic [1:0] KIND_INIT = lnlw_pkg::KIND_INIT;
    localparam logic [1:0] KIND_FREQ = lnlw_pkg::KIND_FREQ;
    localparam logic [1:0] KIND_RES  = lnlw_pkg::KIND_RES;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Byte layout toward the shift register
    localparam logic [7:0] EN_MASK = 8'h80;
    localparam logic [7:0] RS_MASK = 8'h40;

    // Panel commands and character codes
    localparam logic [3:0] WAKE_NIB    = 4'h3;
    localparam logic [3:0] FOURBIT_NIB = 4'h2;
    localparam logic [7:0] LCD_FUNC_SET = 8'h28;
    localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
    localparam logic [7:0] LCD_ENTRY    = 8'h06;
    localparam logic [7:0] LCD_CLEAR    = 8'h01;
    localparam logic [7:0] LCD_LINE1    = 8'h80;
    localparam logic [7:0] LCD_LINE2    = 8'hC0;
    localparam logic [7:0] ASC_F        = 8'h46;
    localparam logic [7:0] ASC_R        = 8'h52;
    localparam logic [7:0] ASC_COLON    = 8'h3A;
    localparam logic [7:0] ASC_H        = 8'h48;
    localparam logic [7:0] ASC_Z        = 8'h7A;
    localparam logic [7:0] ASC_ZERO     = 8'h30;
    localparam logic [7:0] GLYPH_OHM    = 8'hF4;

    // ADC scaling
    localparam int unsigned ADC_FULL = 4095;
    localparam int unsigned OHM_FULL = 5000;

    localparam int RANDOM_ITEMS = 305;
    localparam int TAIL_CYCLES  = 100;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] spi_byte;
        logic       is_last;
    } lcd_byte_t;

    // -----------------------------------------------------------------------
    // Expected byte stream and checker
    // -----------------------------------------------------------------------
    class lcd_byte_board;
        lcd_byte_t expected_bytes[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // one nibble: enable low, high, low
        function void push_nibble(logic [3:0] nib, logic rs);
            lcd_byte_t e;
            e.spi_byte = {4'h0, nib} | (rs ? RS_MASK : 8'h00);
            e.is_last  = 1'b0;
            expected_bytes.push_back(e);
            e.spi_byte = e.spi_byte | EN_MASK;
            expected_bytes.push_back(e);
            e.spi_byte = e.spi_byte & ~EN_MASK;
            expected_bytes.push_back(e);
        endfunction

        // high nibble first
        function void push_char(logic [7:0] b, logic rs);
            push_nibble(b[7:4], rs);
            push_nibble(b[3:0], rs);
        endfunction

        function void push_digits(int unsigned v);
            push_char(ASC_ZERO + 8'((v / 1000) % 10), 1'b1);
            push_char(ASC_ZERO + 8'((v / 100) % 10), 1'b1);
            push_char(ASC_ZERO + 8'((v / 10) % 10), 1'b1);
            push_char(ASC_ZERO + 8'(v % 10), 1'b1);
        endfunction

        // expand one accepted request into its byte stream
        function void add_request(logic [1:0] k, logic [15:0] v);
            int          start_size;
            int unsigned code;
            int unsigned ohms;
            start_size = expected_bytes.size();
            case (k)
                KIND_INIT:
                begin
                    repeat (3) push_nibble(WAKE_NIB, 1'b0);
                    push_nibble(FOURBIT_NIB, 1'b0);
                    push_char(LCD_FUNC_SET, 1'b0);
                    push_char(LCD_DISP_ON, 1'b0);
                    push_char(LCD_ENTRY, 1'b0);
                    push_char(LCD_CLEAR, 1'b0);
                end
                KIND_FREQ:
                begin
                    push_char(LCD_LINE1, 1'b0);
                    push_char(ASC_F, 1'b1);
                    push_char(ASC_COLON, 1'b1);
                    push_digits(int'(v) % 10000);
                    push_char(ASC_H, 1'b1);
                    push_char(ASC_Z, 1'b1);
                end
                KIND_RES:
                begin
                    code = (v > ADC_FULL) ? ADC_FULL : int'(v);
                    ohms = code * OHM_FULL / ADC_FULL;
                    push_char(LCD_LINE2, 1'b0);
                    push_char(ASC_R, 1'b1);
                    push_char(ASC_COLON, 1'b1);
                    push_digits(ohms);
                    push_char(GLYPH_OHM, 1'b1);
                end
                default:
                begin
                    // unused kind: no bytes
                end
            endcase
            if (expected_bytes.size() > start_size)
                expected_bytes[expected_bytes.size() - 1].is_last = 1'b1;
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s", $realtime, msg);
        endfunction

        function void check_byte(logic [7:0] b, logic l);
            lcd_byte_t e;
            if (expected_bytes.size() == 0)
            begin
                note_error($sformatf("unexpected byte %02h last %0b", b, l));
                return;
            end
            e = expected_bytes.pop_front();
            if (b !== e.spi_byte)
                note_error($sformatf("spi_byte expected %02h got %02h",
                                     e.spi_byte, b));
            if (l !== e.is_last)
                note_error($sformatf("last expected %0b got %0b (byte %02h)",
                                     e.is_last, l, b));
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [1:0]  kind;
    logic [15:0] value;
    logic        busy;
    logic        strobe;
    logic [7:0]  spi_byte;
    logic        last;

    lcd_byte_board board;

    lcd_nibble_line_writer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .kind     (kind),
        .value    (value),
        .busy     (busy),
        .strobe   (strobe),
        .spi_byte (spi_byte),
        .last     (last)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_byte(spi_byte, last);
    end

    // Watchdog
    initial
    begin
        #500000;
        $display("tb_lcd_nibble_line_writer: errors");
        $finish;
    end

    // Call at a falling edge; returns at a falling edge after busy reads low
    task automatic send_request(input logic [1:0] k, input logic [15:0] v,
                                input int gap);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        kind  = k;
        value = v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.add_request(k, v);
        @(negedge clk);
    endtask

    // Hold off until the panel stream has caught up
    task automatic wait_for_drain();
        start = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 4095));
            1:       return 16'($urandom_range(4088, 4103));
            2:       return 16'($urandom_range(9990, 10010));
            3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [1:0] pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return KIND_INIT;
        else if (r < 52)
            return KIND_FREQ;
        else if (r < 93)
            return KIND_RES;
        else
            return KIND_NONE;
    endfunction

    // Stimulus
    initial
    begin
        int         done;
        int         burst_left;
        int         gap;
        logic [1:0] k;

        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        kind  = KIND_INIT;
        value = 16'h0000;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: power-up, field extremes, mod and saturation edges
        send_request(KIND_INIT, 16'h0000, 0);
        send_request(KIND_FREQ, 16'd0, 0);
        send_request(KIND_FREQ, 16'd9999, 0);
        send_request(KIND_FREQ, 16'd10000, 3);
        send_request(KIND_FREQ, 16'hFFFF, 0);
        send_request(KIND_FREQ, 16'hAAAA, 0);
        send_request(KIND_FREQ, 16'h5555, 7);
        send_request(KIND_RES, 16'd0, 0);
        send_request(KIND_RES, 16'd1, 0);
        send_request(KIND_RES, 16'd819, 0);
        send_request(KIND_RES, 16'd2047, 2);
        send_request(KIND_RES, 16'd4094, 0);
        send_request(KIND_RES, 16'd4095, 0);
        send_request(KIND_RES, 16'd4096, 0);
        send_request(KIND_RES, 16'hFFFF, 0);
        wait_for_drain();
        // unused kind, back to back and alone
        send_request(KIND_NONE, 16'hFFFF, 0);
        send_request(KIND_NONE, 16'h0000, 0);
        send_request(KIND_INIT, 16'hFFFF, 0);
        send_request(KIND_FREQ, 16'd1234, 16);
        send_request(KIND_NONE, 16'h1234, 0);
        send_request(KIND_RES, 16'd3000, 0);
        wait_for_drain();

        // random: mostly gapped, with idle-free bursts and occasional drains
        done       = 0;
        burst_left = 0;
        while (done < RANDOM_ITEMS)
        begin
            if (burst_left > 0)
            begin
                gap = 0;
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(0, 16);
                if ($urandom_range(0, 19) == 0)
                    burst_left = $urandom_range(4, 12);
            end
            if (done == RANDOM_ITEMS / 2 || $urandom_range(0, 59) == 0)
                wait_for_drain();
            k = pick_kind();
            send_request(k, pick_value(), gap);
            if (k != KIND_NONE)
                done++;
        end

        // let everything settle
        start = 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.pending() != 0)
            board.note_error($sformatf("%0d bytes never arrived",
                                       board.pending()));

        if (board.errors == 0)
            $display("tb_lcd_nibble_line_writer: clean");
        else
            $display("tb_lcd_nibble_line_writer: errors");
        $finish;
    end

endmodule
